>>> hw/rtl/smac_pkg.sv
// ----------------------------------------------------------------------------
// smac_pkg
// Shared types, codes and helper functions of the subset-match assumption
// cache.
// ----------------------------------------------------------------------------
package smac_pkg;

	// Field widths
	localparam int TERM_W = 31;
	localparam int SET_W  = 64;
	localparam int IDX_W  = 6;
	localparam int KIND_W = 3;

	// Default table sizes
	localparam int ATOM_SLOTS_DEF  = 64;
	localparam int SAT_SLOTS_DEF   = 16;
	localparam int UNSAT_SLOTS_DEF = 16;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_REGISTER     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RECORD_SAT   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RECORD_UNSAT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LOOKUP_SAT   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LOOKUP_UNSAT = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TERM_W-1:0] term;
		logic [SET_W-1:0]  atom_set;
	} smac_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  atom_slot;
		logic              hit;
		logic [TERM_W-1:0] conflict_term;
		logic              term_valid;
		logic              last;
		logic              status;
	} smac_rsp_t;

	// Shared compare unit operations
	typedef enum logic [0:0] {
		CMP_EQ,
		CMP_SUBSET
	} cmp_op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_BIT,
		ST_BIT_OUT
	} state_t;

	// Address width of a table of the given depth
	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// Width of a counter that can hold the depth itself
	function automatic int cnt_w(input int depth);
		return $clog2(depth + 1);
	endfunction

endpackage

>>> hw/rtl/smac_ram.sv
// ----------------------------------------------------------------------------
// smac_ram
// Single write port, single read port table with registered read data.
// ----------------------------------------------------------------------------
module smac_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [smac_pkg::addr_w(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [smac_pkg::addr_w(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/smac_cmp.sv
// ----------------------------------------------------------------------------
// smac_cmp
// Shared compare unit: word equality for the term search, subset test for
// the row scans.
// ----------------------------------------------------------------------------
module smac_cmp (
	input  smac_pkg::cmp_op_t               op,
	input  logic [smac_pkg::SET_W-1:0]      a,
	input  logic [smac_pkg::SET_W-1:0]      b,
	output logic                            match
);

	// Equality, or a is a subset of b
	always_comb begin
		case (op)
			smac_pkg::CMP_EQ:     match = ((a ^ b) == '0);
			smac_pkg::CMP_SUBSET: match = ((a & ~b) == '0);
			default:              match = 1'b0;
		endcase
	end

endmodule

>>> hw/rtl/subset_match_assumption_cache_unit.sv
// ----------------------------------------------------------------------------
// subset_match_assumption_cache_unit
// Term index table plus sat and unsat atom-set tables with subset queries.
// ----------------------------------------------------------------------------
// One item is handled at a time; req_ready is high only while the sequencer
// is idle, and a result waiting in the output register does not hold it off.
// Records go from idle to the emit state and back. register_atom and both
// lookups scan their table through its single read port, one entry per
// cycle, with one shared compare unit, ending early on a hit. An unsat
// hit then walks the core one clear bit position per cycle; each set bit
// takes an extra state that reads the term table and then waits out any
// output stall. The tables need no clearing after reset.
// ----------------------------------------------------------------------------
module subset_match_assumption_cache_unit #(
	parameter int ATOM_SLOTS  = smac_pkg::ATOM_SLOTS_DEF,
	parameter int SAT_SLOTS   = smac_pkg::SAT_SLOTS_DEF,
	parameter int UNSAT_SLOTS = smac_pkg::UNSAT_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  smac_pkg::smac_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output smac_pkg::smac_rsp_t rsp
);

	localparam int AAW = smac_pkg::addr_w(ATOM_SLOTS);
	localparam int SAW = smac_pkg::addr_w(SAT_SLOTS);
	localparam int UAW = smac_pkg::addr_w(UNSAT_SLOTS);
	localparam int ACW = smac_pkg::cnt_w(ATOM_SLOTS);
	localparam int SCW = smac_pkg::cnt_w(SAT_SLOTS);
	localparam int UCW = smac_pkg::cnt_w(UNSAT_SLOTS);
	localparam int XW0 = (ACW > SCW) ? ACW : SCW;
	localparam int XW  = (XW0 > UCW) ? XW0 : UCW;
	localparam int CNW = smac_pkg::IDX_W + 1;

	// Control state
	smac_pkg::state_t                  state_q, state_d;
	logic [ACW-1:0]                    atom_count_q;
	logic [SCW-1:0]                    sat_count_q;
	logic [UCW-1:0]                    unsat_count_q;
	logic                              cmp_vld_s1;
	logic                              rsp_valid_q;

	// Item and scan payload
	logic [smac_pkg::KIND_W-1:0]       kind_q;
	logic [smac_pkg::TERM_W-1:0]       term_q;
	logic [smac_pkg::SET_W-1:0]        set_q;
	logic [XW-1:0]                     scan_idx_q;
	logic [XW-1:0]                     cmp_idx_s1;
	logic                              found_q;
	logic [smac_pkg::IDX_W-1:0]        hit_idx_q;
	logic [smac_pkg::SET_W-1:0]        rem_q;
	logic [smac_pkg::IDX_W-1:0]        bit_q;
	smac_pkg::smac_rsp_t               rsp_q, rsp_d;

	// Sequencer controls
	logic                              accept;
	logic                              can_load;
	logic                              load_rsp;
	logic                              scan_issue;
	logic                              scan_more;
	logic                              scan_hit;
	logic [XW-1:0]                     scan_lim;
	logic                              wr_atom, wr_sat, wr_unsat;
	logic                              bit_rd, bit_step;
	logic                              bit_known;
	logic                              atom_full, sat_full, unsat_full;

	// Table ports
	logic [AAW-1:0]                    atom_raddr;
	logic                              atom_re, sat_re, unsat_re;
	logic [smac_pkg::TERM_W-1:0]       atom_rd;
	logic [smac_pkg::SET_W-1:0]        sat_rd, unsat_rd;

	// Shared compare unit
	smac_pkg::cmp_op_t                 cmp_op;
	logic [smac_pkg::SET_W-1:0]        cmp_a, cmp_b;
	logic                              cmp_match;

	assign req_ready = (state_q == smac_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign can_load  = !rsp_valid_q || rsp_ready;

	assign atom_full  = (atom_count_q == ACW'(ATOM_SLOTS));
	assign sat_full   = (sat_count_q == SCW'(SAT_SLOTS));
	assign unsat_full = (unsat_count_q == UCW'(UNSAT_SLOTS));
	assign bit_known  = (CNW'(bit_q) < CNW'(atom_count_q));

	// Tables
	smac_ram #(.DEPTH(ATOM_SLOTS), .WIDTH(smac_pkg::TERM_W)) u_atom_ram (
		.clk   (clk),
		.we    (wr_atom),
		.waddr (atom_count_q[AAW-1:0]),
		.wdata (term_q),
		.re    (atom_re),
		.raddr (atom_raddr),
		.rdata (atom_rd)
	);

	smac_ram #(.DEPTH(SAT_SLOTS), .WIDTH(smac_pkg::SET_W)) u_sat_ram (
		.clk   (clk),
		.we    (wr_sat),
		.waddr (sat_count_q[SAW-1:0]),
		.wdata (set_q),
		.re    (sat_re),
		.raddr (scan_idx_q[SAW-1:0]),
		.rdata (sat_rd)
	);

	smac_ram #(.DEPTH(UNSAT_SLOTS), .WIDTH(smac_pkg::SET_W)) u_unsat_ram (
		.clk   (clk),
		.we    (wr_unsat),
		.waddr (unsat_count_q[UAW-1:0]),
		.wdata (set_q),
		.re    (unsat_re),
		.raddr (scan_idx_q[UAW-1:0]),
		.rdata (unsat_rd)
	);

	// Read port steering
	assign atom_re    = (scan_issue && (kind_q == smac_pkg::KIND_REGISTER)) || bit_rd;
	assign sat_re     = scan_issue && (kind_q == smac_pkg::KIND_LOOKUP_SAT);
	assign unsat_re   = scan_issue && (kind_q == smac_pkg::KIND_LOOKUP_UNSAT);
	assign atom_raddr = (state_q == smac_pkg::ST_BIT) ? bit_q[AAW-1:0] : scan_idx_q[AAW-1:0];

	// Operand selection for the compare unit
	always_comb begin
		case (kind_q)
			smac_pkg::KIND_REGISTER: begin
				cmp_op = smac_pkg::CMP_EQ;
				cmp_a  = smac_pkg::SET_W'(term_q);
				cmp_b  = smac_pkg::SET_W'(atom_rd);
			end
			smac_pkg::KIND_LOOKUP_SAT: begin
				cmp_op = smac_pkg::CMP_SUBSET;
				cmp_a  = set_q;
				cmp_b  = sat_rd;
			end
			default: begin
				cmp_op = smac_pkg::CMP_SUBSET;
				cmp_a  = unsat_rd;
				cmp_b  = set_q;
			end
		endcase
	end

	smac_cmp u_cmp (
		.op    (cmp_op),
		.a     (cmp_a),
		.b     (cmp_b),
		.match (cmp_match)
	);

	// Scan bounds
	always_comb begin
		case (kind_q)
			smac_pkg::KIND_REGISTER:   scan_lim = XW'(atom_count_q);
			smac_pkg::KIND_LOOKUP_SAT: scan_lim = XW'(sat_count_q);
			default:                   scan_lim = XW'(unsat_count_q);
		endcase
	end

	assign scan_more = (scan_idx_q < scan_lim);
	assign scan_hit  = cmp_vld_s1 && cmp_match;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer outputs
	always_comb begin
		state_d    = state_q;
		scan_issue = 1'b0;
		load_rsp   = 1'b0;
		wr_atom    = 1'b0;
		wr_sat     = 1'b0;
		wr_unsat   = 1'b0;
		bit_rd     = 1'b0;
		bit_step   = 1'b0;
		rsp_d      = '0;
		rsp_d.last = 1'b1;
		case (state_q)
			smac_pkg::ST_IDLE: begin
				if (req_valid) begin
					case (req.kind)
						smac_pkg::KIND_REGISTER,
						smac_pkg::KIND_LOOKUP_SAT,
						smac_pkg::KIND_LOOKUP_UNSAT: state_d = smac_pkg::ST_SCAN;
						smac_pkg::KIND_RECORD_SAT,
						smac_pkg::KIND_RECORD_UNSAT: state_d = smac_pkg::ST_EMIT;
						default:                     state_d = smac_pkg::ST_IDLE;
					endcase
				end
			end
			smac_pkg::ST_SCAN: begin
				scan_issue = scan_more && !scan_hit;
				if (scan_hit || (!scan_more && !cmp_vld_s1)) begin
					state_d = smac_pkg::ST_EMIT;
				end
			end
			smac_pkg::ST_EMIT: begin
				case (kind_q)
					smac_pkg::KIND_REGISTER: begin
						if (found_q) begin
							rsp_d.atom_slot = hit_idx_q;
						end else if (atom_full) begin
							rsp_d.status = 1'b1;
						end else begin
							rsp_d.atom_slot = smac_pkg::IDX_W'(atom_count_q);
							wr_atom         = can_load;
						end
					end
					smac_pkg::KIND_RECORD_SAT: begin
						if (sat_full) begin
							rsp_d.status = 1'b1;
						end else begin
							wr_sat = can_load;
						end
					end
					smac_pkg::KIND_RECORD_UNSAT: begin
						if (unsat_full) begin
							rsp_d.status = 1'b1;
						end else begin
							wr_unsat = can_load;
						end
					end
					default: begin
						rsp_d.hit = found_q;
					end
				endcase
				// a non-empty matching core streams its atoms instead
				if ((kind_q == smac_pkg::KIND_LOOKUP_UNSAT) && found_q && (rem_q != '0)) begin
					state_d = smac_pkg::ST_BIT;
				end else if (can_load) begin
					load_rsp = 1'b1;
					state_d  = smac_pkg::ST_IDLE;
				end
			end
			smac_pkg::ST_BIT: begin
				if (rem_q[0]) begin
					bit_rd  = 1'b1;
					state_d = smac_pkg::ST_BIT_OUT;
				end else begin
					bit_step = 1'b1;
				end
			end
			smac_pkg::ST_BIT_OUT: begin
				rsp_d.atom_slot     = bit_q;
				rsp_d.hit           = 1'b1;
				rsp_d.conflict_term = bit_known ? atom_rd : '0;
				rsp_d.term_valid    = 1'b1;
				rsp_d.last          = (rem_q[smac_pkg::SET_W-1:1] == '0);
				if (can_load) begin
					load_rsp = 1'b1;
					bit_step = 1'b1;
					state_d  = rsp_d.last ? smac_pkg::ST_IDLE : smac_pkg::ST_BIT;
				end
			end
			default: begin
				state_d = smac_pkg::ST_IDLE;
			end
		endcase
	end

	// Table fill counts, compare stage valid and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_count_q  <= '0;
			sat_count_q   <= '0;
			unsat_count_q <= '0;
			cmp_vld_s1    <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (wr_atom) begin
				atom_count_q <= atom_count_q + 1'b1;
			end
			if (wr_sat) begin
				sat_count_q <= sat_count_q + 1'b1;
			end
			if (wr_unsat) begin
				unsat_count_q <= unsat_count_q + 1'b1;
			end
			cmp_vld_s1 <= scan_issue;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Item, scan and stream payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= req.kind;
			term_q     <= req.term;
			set_q      <= req.atom_set;
			scan_idx_q <= '0;
			found_q    <= 1'b0;
			bit_q      <= '0;
		end else begin
			if (scan_issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (scan_hit) begin
				found_q   <= 1'b1;
				hit_idx_q <= smac_pkg::IDX_W'(cmp_idx_s1);
				rem_q     <= unsat_rd;
			end else if (bit_step) begin
				rem_q <= rem_q >> 1;
			end
			if (bit_step) begin
				bit_q <= bit_q + 1'b1;
			end
		end
		cmp_idx_s1 <= scan_idx_q;
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> hw/rtl/smac_chk.sv
// ----------------------------------------------------------------------------
// smac_chk
// Port-level checks of the subset-match assumption cache, bound to the top.
// ----------------------------------------------------------------------------
module smac_chk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  smac_pkg::smac_req_t req,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  smac_pkg::smac_rsp_t rsp
);

	// A stalled result item holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item changed while stalled");

	// A valid item kind keeps the block busy in the cycle after it is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.kind <= smac_pkg::KIND_LOOKUP_UNSAT) |=> !req_ready)
		else $error("block ready straight after taking an item");

	// Streamed core atoms only come from a hit and never with a full status
	a_stream_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.term_valid |-> rsp.hit && !rsp.status)
		else $error("core atom without a hit");

	// Any item without a core atom is single and carries no term
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.term_valid |-> rsp.last && (rsp.conflict_term == '0))
		else $error("non-stream item malformed");

endmodule

bind subset_match_assumption_cache_unit smac_chk u_smac_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

>>> tb/subset_match_assumption_cache_unit_tb.sv
// ----------------------------------------------------------------------------
// subset_match_assumption_cache_unit_tb
// Self-checking bench for the subset-match assumption cache. A scoreboard
// class keeps its own copy of the term, sat and unsat tables, predicts every
// answer of each accepted item and checks the answers in order. Stimulus is
// a directed opening followed by random traffic, with random gaps and stalls
// on both handshakes.
// ----------------------------------------------------------------------------
module subset_match_assumption_cache_unit_tb;

	localparam int          RANDOM_ITEMS = 480;
	localparam int          HOLD_AT      = 160;
	localparam int          DRAIN_AT     = 320;
	localparam int          LONG_HOLD    = 400;
	localparam int          TAIL_CYCLES  = 200;
	localparam int unsigned CYCLE_LIMIT  = 10_000_000;

	localparam logic                        STATUS_OK        = 1'b0;
	localparam logic                        STATUS_FULL      = 1'b1;
	localparam logic [smac_pkg::KIND_W-1:0] KIND_RESERVED_LO = 3'd5;

	// Answer predictor and in-order checker
	class answer_scoreboard;
		logic [smac_pkg::TERM_W-1:0] term_of [smac_pkg::ATOM_SLOTS_DEF];
		logic [smac_pkg::SET_W-1:0]  sat_rows [smac_pkg::SAT_SLOTS_DEF];
		logic [smac_pkg::SET_W-1:0]  unsat_rows [smac_pkg::UNSAT_SLOTS_DEF];
		int                          atoms_used;
		int                          sat_used;
		int                          unsat_used;
		smac_pkg::smac_rsp_t         due_answers[$];
		int                          fail_count;

		function int pending();
			return due_answers.size();
		endfunction

		function string show(input smac_pkg::smac_rsp_t a);
			return $sformatf("idx=%0d hit=%0b term=%h tv=%0b last=%0b status=%0b",
				a.atom_slot, a.hit, a.conflict_term, a.term_valid, a.last, a.status);
		endfunction

		// Work out the answers of one accepted item and update the tables
		function void note_request(input smac_pkg::smac_req_t item);
			smac_pkg::smac_rsp_t        ans;
			logic [smac_pkg::SET_W-1:0] core;
			int                         hit_row;
			bit                         found;
			ans = '0;
			ans.last = 1'b1;
			ans.status = STATUS_OK;
			case (item.kind)
			smac_pkg::KIND_REGISTER: begin
				found = 1'b0;
				for (int i = 0; i < atoms_used; i++) begin
					if (!found && term_of[i] == item.term) begin
						ans.atom_slot = smac_pkg::IDX_W'(i);
						found = 1'b1;
					end
				end
				if (!found) begin
					if (atoms_used >= smac_pkg::ATOM_SLOTS_DEF) begin
						ans.status = STATUS_FULL;
					end else begin
						term_of[atoms_used] = item.term;
						ans.atom_slot = smac_pkg::IDX_W'(atoms_used);
						atoms_used++;
					end
				end
				due_answers.push_back(ans);
			end
			smac_pkg::KIND_RECORD_SAT: begin
				if (sat_used >= smac_pkg::SAT_SLOTS_DEF) begin
					ans.status = STATUS_FULL;
				end else begin
					sat_rows[sat_used] = item.atom_set;
					sat_used++;
				end
				due_answers.push_back(ans);
			end
			smac_pkg::KIND_RECORD_UNSAT: begin
				if (unsat_used >= smac_pkg::UNSAT_SLOTS_DEF) begin
					ans.status = STATUS_FULL;
				end else begin
					unsat_rows[unsat_used] = item.atom_set;
					unsat_used++;
				end
				due_answers.push_back(ans);
			end
			smac_pkg::KIND_LOOKUP_SAT: begin
				for (int i = 0; i < sat_used; i++) begin
					if ((item.atom_set & ~sat_rows[i]) == '0) ans.hit = 1'b1;
				end
				due_answers.push_back(ans);
			end
			smac_pkg::KIND_LOOKUP_UNSAT: begin
				// scan downwards so the oldest matching core wins
				hit_row = -1;
				for (int i = unsat_used - 1; i >= 0; i--) begin
					if ((unsat_rows[i] & ~item.atom_set) == '0) hit_row = i;
				end
				if (hit_row < 0 || unsat_rows[hit_row] == '0) begin
					ans.hit = (hit_row >= 0);
					due_answers.push_back(ans);
				end else begin
					core = unsat_rows[hit_row];
					for (int b = 0; b < smac_pkg::SET_W; b++) begin
						if (core[b]) begin
							ans = '0;
							ans.hit = 1'b1;
							ans.term_valid = 1'b1;
							ans.atom_slot = smac_pkg::IDX_W'(b);
							// atoms not yet registered stream a zero term
							ans.conflict_term = (b < atoms_used) ? term_of[b] : '0;
							ans.last = ((core >> (b + 1)) == '0);
							due_answers.push_back(ans);
						end
					end
				end
			end
			default: begin
				// reserved kinds: no answer, no change
			end
			endcase
		endfunction

		// Compare one accepted answer with the oldest prediction
		function void check_response(input smac_pkg::smac_rsp_t got);
			smac_pkg::smac_rsp_t want;
			if (due_answers.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: answer with nothing predicted: %s", $time, show(got));
				return;
			end
			want = due_answers.pop_front();
			if (got.atom_slot !== want.atom_slot || got.hit !== want.hit ||
			    got.conflict_term !== want.conflict_term ||
			    got.term_valid !== want.term_valid || got.last !== want.last ||
			    got.status !== want.status) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: answer mismatch\n  expected %s\n  actual   %s",
						$time, show(want), show(got));
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	smac_pkg::smac_req_t req;
	logic                rsp_valid;
	logic                rsp_ready;
	smac_pkg::smac_rsp_t rsp;

	answer_scoreboard answers = new();

	// what the stimulus has put into the tables so far, for shaping queries
	logic [smac_pkg::TERM_W-1:0] known_terms[$];
	logic [smac_pkg::SET_W-1:0]  sat_sent[$];
	logic [smac_pkg::SET_W-1:0]  unsat_sent[$];
	int                          burst_left;
	bit                          hold_rsp;
	int unsigned                 cycle_count;

	subset_match_assumption_cache_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Answer monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) answers.check_response(rsp);
	end

	// Receiver: random ready runs and stalls, plus one long hold on request
	initial begin : rsp_side
		bit ready_now;
		int run_left;
		ready_now = 1'b0;
		run_left = 0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				ready_now = 1'b0;
				run_left = LONG_HOLD;
			end else if (run_left == 0) begin
				ready_now = !ready_now;
				if (ready_now)
					run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
						: $urandom_range(1, 12);
				else
					run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
						: $urandom_range(1, 3);
			end
			run_left--;
			rsp_ready <= ready_now;
		end
	end

	// Watchdog
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic smac_pkg::smac_req_t make_item(
		input logic [smac_pkg::KIND_W-1:0] kind,
		input logic [smac_pkg::TERM_W-1:0] term,
		input logic [smac_pkg::SET_W-1:0] atom_set);
		smac_pkg::smac_req_t item;
		item.kind = kind;
		item.term = term;
		item.atom_set = atom_set;
		return item;
	endfunction

	// Sender gap: mostly none or short, a few long, and gap-free bursts
	function automatic int pick_gap();
		int roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(0, 19);
		if (roll == 0) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (roll < 3) return $urandom_range(10, 40);
		if (roll < 10) return $urandom_range(1, 3);
		return 0;
	endfunction

	// One to four bits, about half the time limited to the atoms already registered
	function automatic logic [smac_pkg::SET_W-1:0] sparse_set();
		logic [smac_pkg::SET_W-1:0] s;
		int                         top;
		s = '0;
		top = smac_pkg::SET_W - 1;
		if (known_terms.size() > 0 && $urandom_range(0, 1) == 1) top = known_terms.size() - 1;
		repeat ($urandom_range(1, 4)) s[$urandom_range(0, top)] = 1'b1;
		return s;
	endfunction

	function automatic void track_sent(input smac_pkg::smac_req_t item);
		bit seen;
		seen = 1'b0;
		case (item.kind)
		smac_pkg::KIND_REGISTER: begin
			foreach (known_terms[i]) if (known_terms[i] == item.term) seen = 1'b1;
			if (!seen && known_terms.size() < smac_pkg::ATOM_SLOTS_DEF)
				known_terms.push_back(item.term);
		end
		smac_pkg::KIND_RECORD_SAT:
			if (sat_sent.size() < smac_pkg::SAT_SLOTS_DEF) sat_sent.push_back(item.atom_set);
		smac_pkg::KIND_RECORD_UNSAT:
			if (unsat_sent.size() < smac_pkg::UNSAT_SLOTS_DEF)
				unsat_sent.push_back(item.atom_set);
		default: begin
		end
		endcase
	endfunction

	// Random item, mostly queries built from stored rows so lookups hit
	function automatic smac_pkg::smac_req_t random_item();
		smac_pkg::smac_req_t item;
		int                  roll;
		int                  pick;
		roll = $urandom_range(0, 99);
		item.term = smac_pkg::TERM_W'($urandom);
		item.atom_set = {$urandom, $urandom};
		if (roll < 25) begin
			item.kind = smac_pkg::KIND_REGISTER;
			if (known_terms.size() > 0 && $urandom_range(0, 9) < 4)
				item.term = known_terms[$urandom_range(0, known_terms.size() - 1)];
		end else if (roll < 35) begin
			item.kind = smac_pkg::KIND_RECORD_SAT;
			if ($urandom_range(0, 3) == 0) item.atom_set |= {$urandom, $urandom};
		end else if (roll < 45) begin
			item.kind = smac_pkg::KIND_RECORD_UNSAT;
			// the empty core goes last, since it matches every query
			if (unsat_sent.size() == smac_pkg::UNSAT_SLOTS_DEF - 1) item.atom_set = '0;
			else if ($urandom_range(0, 5) != 0) item.atom_set = sparse_set();
		end else if (roll < 68) begin
			item.kind = smac_pkg::KIND_LOOKUP_SAT;
			pick = $urandom_range(0, 9);
			if (sat_sent.size() > 0 && pick < 6)
				item.atom_set = sat_sent[$urandom_range(0, sat_sent.size() - 1)]
					& {$urandom, $urandom};
			else if (pick < 8)
				item.atom_set = sparse_set();
		end else if (roll < 96) begin
			item.kind = smac_pkg::KIND_LOOKUP_UNSAT;
			pick = $urandom_range(0, 19);
			if (pick == 0)
				item.atom_set = '1;
			else if (unsat_sent.size() > 0 && pick < 13)
				item.atom_set = unsat_sent[$urandom_range(0, unsat_sent.size() - 1)]
					| sparse_set();
			else if (pick < 18)
				item.atom_set = sparse_set();
		end else begin
			item.kind = KIND_RESERVED_LO + smac_pkg::KIND_W'($urandom_range(0, 2));
		end
		return item;
	endfunction

	task automatic send_item(input smac_pkg::smac_req_t item, input int gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		answers.note_request(item);
		track_sent(item);
	endtask

	// Stop offering and wait for every predicted answer
	task automatic drain_answers();
		req_valid <= 1'b0;
		@(posedge clk);
		while (answers.pending() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		smac_pkg::smac_req_t item;
		int                  sent;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Empty tables miss
		send_item(make_item(smac_pkg::KIND_LOOKUP_SAT, smac_pkg::TERM_W'($urandom), '0),
			pick_gap());
		send_item(make_item(smac_pkg::KIND_LOOKUP_UNSAT, smac_pkg::TERM_W'($urandom), '1),
			pick_gap());
		// Term extremes, then a repeat that must be found
		send_item(make_item(smac_pkg::KIND_REGISTER, '0, {$urandom, $urandom}), pick_gap());
		send_item(make_item(smac_pkg::KIND_REGISTER, '1, {$urandom, $urandom}), pick_gap());
		send_item(make_item(smac_pkg::KIND_REGISTER, '0, '1), pick_gap());
		// Sat rows: zero row, edge bits
		send_item(make_item(smac_pkg::KIND_RECORD_SAT, smac_pkg::TERM_W'($urandom), '0),
			pick_gap());
		send_item(make_item(smac_pkg::KIND_LOOKUP_SAT, smac_pkg::TERM_W'($urandom), '0),
			pick_gap());
		send_item(make_item(smac_pkg::KIND_LOOKUP_SAT, smac_pkg::TERM_W'($urandom), 64'h1),
			pick_gap());
		send_item(make_item(smac_pkg::KIND_RECORD_SAT, '1, 64'h8000_0000_0000_0001),
			pick_gap());
		send_item(make_item(smac_pkg::KIND_LOOKUP_SAT, '1, 64'h8000_0000_0000_0000),
			pick_gap());
		// Full core: sixty-four answers, most atoms not yet registered
		send_item(make_item(smac_pkg::KIND_RECORD_UNSAT, smac_pkg::TERM_W'($urandom), '1),
			pick_gap());
		send_item(make_item(smac_pkg::KIND_LOOKUP_UNSAT, smac_pkg::TERM_W'($urandom), '1),
			pick_gap());
		// Core of atoms one and sixty-three, then a query that hits it and one that misses it
		send_item(make_item(smac_pkg::KIND_RECORD_UNSAT, '0, 64'h8000_0000_0000_0002),
			pick_gap());
		send_item(make_item(smac_pkg::KIND_LOOKUP_UNSAT, '0, 64'hC000_0000_0000_0003),
			pick_gap());
		send_item(make_item(smac_pkg::KIND_LOOKUP_UNSAT, '1, 64'h2), pick_gap());
		// Reserved kinds
		send_item(make_item(KIND_RESERVED_LO, '1, '1), pick_gap());
		send_item(make_item(KIND_RESERVED_LO + 3'd1, '0, '0), pick_gap());
		send_item(make_item(KIND_RESERVED_LO + 3'd2, smac_pkg::TERM_W'($urandom),
			{$urandom, $urandom}), pick_gap());
		send_item(make_item(smac_pkg::KIND_REGISTER, smac_pkg::TERM_W'($urandom), '0),
			pick_gap());

		// Random traffic
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent == HOLD_AT) begin
				// receiver holds off while items keep coming
				hold_rsp = 1'b1;
				burst_left = 24;
			end
			if (sent == DRAIN_AT) drain_answers();
			item = random_item();
			if (item.kind <= smac_pkg::KIND_LOOKUP_UNSAT) sent++;
			send_item(item, pick_gap());
		end

		drain_answers();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (answers.fail_count == 0 && answers.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
